// ===== rtl/ardsu_pkg.sv =====
// Shared types and constants for the analog rotary decode and scale unit.
// Depends on nothing; every other file in rtl imports it.

package ardsu_pkg;

    localparam int MAX_POSITIONS_DEF = 8;

    localparam int RAW_W   = 12;
    localparam int MV_W    = 16;
    localparam int POS_W   = 3;
    localparam int CNT_W   = POS_W + 1;
    localparam int TOL_W   = 16;
    localparam int GAIN_W  = 32;
    localparam int PROD_W  = 48;
    localparam int SCALE_W = 48;
    localparam int WIN_W   = MV_W + 2;

    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_CONTROL   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COUNT     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TOLERANCE = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CENTRE_LO = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CENTRE_HI = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GAIN      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET    = 3'd6;

    localparam int CTL_BLOCK_EN  = 0;
    localparam int CTL_ROTARY_EN = 1;
    localparam int CTL_INVERT    = 2;
    localparam int CTL_SCALE_EN  = 3;

    localparam logic [3:0]        CONTROL_RESET   = 4'd0;
    localparam logic [7:0]        COUNT_RESET     = 8'd2;
    localparam logic [TOL_W-1:0]  TOLERANCE_RESET = 16'd100;
    localparam logic [GAIN_W-1:0] GAIN_RESET      = 32'd65536;
    localparam logic [7:0]        COUNT_MIN       = 8'd2;

    typedef struct packed {
        logic [RAW_W-1:0]         raw;
        logic [MV_W-1:0]          mv;
        logic                     found;
        logic [POS_W-1:0]         pos;
        logic signed [PROD_W-1:0] prod;
    } ardsu_item_t;

endpackage

// ===== rtl/ardsu_cell.sv =====
// One position cell of the window-compare chain: holds one sample in flight
// and tests it against the window of its own position.
// Depends on ardsu_pkg.

module ardsu_cell
    import ardsu_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [MV_W-1:0]    centre,
    input  logic [MV_W-1:0]    centre_prev,
    input  logic [MV_W-1:0]    centre_next,
    input  logic [TOL_W-1:0]   tolerance,
    input  logic               is_first,
    input  logic               is_last,
    input  logic               active,
    input  logic               up_valid,
    output logic               up_ready,
    input  ardsu_item_t        up_item,
    output logic               dn_valid,
    input  logic               dn_ready,
    output ardsu_item_t        dn_item
);

    logic                     valid_reg;
    ardsu_item_t              item_reg;
    ardsu_item_t              item_next;
    logic signed [WIN_W-1:0]  c_s;
    logic signed [WIN_W-1:0]  tol_s;
    logic signed [WIN_W-1:0]  mv_s;
    logic signed [WIN_W-1:0]  gap_lo;
    logic signed [WIN_W-1:0]  gap_hi;
    logic signed [WIN_W-1:0]  half_lo;
    logic signed [WIN_W-1:0]  half_hi;
    logic signed [WIN_W-1:0]  lo;
    logic signed [WIN_W-1:0]  hi;
    logic signed [WIN_W-1:0]  bound_lo;
    logic signed [WIN_W-1:0]  bound_hi;
    logic                     match;

    // Halving rounds toward zero, so a negative gap is nudged up by one first.
    always_comb
    begin
        c_s      = $signed({2'b00, centre});
        tol_s    = $signed({2'b00, tolerance});
        mv_s     = $signed({2'b00, up_item.mv});
        gap_lo   = c_s - $signed({2'b00, centre_prev});
        gap_hi   = $signed({2'b00, centre_next}) - c_s;
        half_lo  = (gap_lo + $signed({{(WIN_W-1){1'b0}}, gap_lo[WIN_W-1]})) >>> 1;
        half_hi  = (gap_hi + $signed({{(WIN_W-1){1'b0}}, gap_hi[WIN_W-1]})) >>> 1;
        lo       = (is_first || (half_lo >= tol_s)) ? tol_s : half_lo;
        hi       = (is_last  || (half_hi >= tol_s)) ? tol_s : half_hi;
        bound_lo = c_s - lo;
        bound_hi = c_s + hi;
        match    = active && (mv_s >= bound_lo) && (mv_s <= bound_hi);

        item_next = up_item;
        if (!up_item.found && match)
        begin
            item_next.found = 1'b1;
            item_next.pos   = POS_W'(IDX);
        end
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/ardsu_out_stage.sv =====
// Result register: applies the enables and inversion, adds the offset to the
// carried product and saturates to 48 bits. Depends on ardsu_pkg.

module ardsu_out_stage
    import ardsu_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [3:0]                control,
    input  logic [CNT_W-1:0]          pos_count,
    input  logic signed [GAIN_W-1:0]  offset,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  ardsu_item_t               up_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [RAW_W-1:0]          raw_out,
    output logic [MV_W-1:0]           millivolts_out,
    output logic [POS_W-1:0]          position_index,
    output logic                      position_valid,
    output logic signed [SCALE_W-1:0] scaled_value
);

    logic                      valid_reg;
    logic [RAW_W-1:0]          raw_reg;
    logic [RAW_W-1:0]          raw_next;
    logic [MV_W-1:0]           mv_reg;
    logic [MV_W-1:0]           mv_next;
    logic [POS_W-1:0]          pos_reg;
    logic [POS_W-1:0]          pos_next;
    logic                      found_reg;
    logic                      found_next;
    logic signed [SCALE_W-1:0] scaled_reg;
    logic signed [SCALE_W-1:0] scaled_next;
    logic signed [PROD_W:0]    sum;
    logic signed [SCALE_W-1:0] sat;

    always_comb
    begin
        sum = $signed({up_item.prod[PROD_W-1], up_item.prod})
            + $signed({{(PROD_W+1-GAIN_W){offset[GAIN_W-1]}}, offset});
        if (sum[PROD_W] != sum[PROD_W-1])
        begin
            sat = sum[PROD_W] ? $signed({1'b1, {(SCALE_W-1){1'b0}}})
                              : $signed({1'b0, {(SCALE_W-1){1'b1}}});
        end
        else
        begin
            sat = sum[SCALE_W-1:0];
        end

        raw_next    = '0;
        mv_next     = '0;
        pos_next    = '0;
        found_next  = 1'b0;
        scaled_next = '0;
        if (control[CTL_BLOCK_EN])
        begin
            raw_next = up_item.raw;
            mv_next  = up_item.mv;
            if (control[CTL_ROTARY_EN] && up_item.found)
            begin
                found_next = 1'b1;
                pos_next   = control[CTL_INVERT]
                           ? POS_W'(pos_count - CNT_W'(1) - {1'b0, up_item.pos})
                           : up_item.pos;
            end
            if (control[CTL_SCALE_EN])
            begin
                scaled_next = sat;
            end
        end
    end

    assign up_ready       = !valid_reg || out_ready;
    assign out_valid      = valid_reg;
    assign raw_out        = raw_reg;
    assign millivolts_out = mv_reg;
    assign position_index = pos_reg;
    assign position_valid = found_reg;
    assign scaled_value   = scaled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            raw_reg    <= raw_next;
            mv_reg     <= mv_next;
            pos_reg    <= pos_next;
            found_reg  <= found_next;
            scaled_reg <= scaled_next;
        end
    end

endmodule

// ===== rtl/analog_rotary_decode_and_scale_unit.sv =====
// Top level of the analog rotary decode and scale unit: register port,
// input multiplier, chain of position cells and result register.
// Depends on ardsu_pkg, ardsu_cell and ardsu_out_stage.
//
//   Channel  Direction  Handshake             Payload
//   in       into unit  in_valid / in_ready   raw_count, sample_millivolts
//   out      from unit  out_valid / out_ready raw_out, millivolts_out, position_index,
//                                             position_valid, scaled_value
//   cfg      into unit  APB psel / penable    paddr, pwdata, prdata
//
// One sample is accepted every cycle unless a stall at the output has filled the chain. A
// sample is captured by the first position cell on its transfer edge, passes through each
// position cell in turn and then the result register, from which it transfers out.
// Every stage holds its own valid bit, so a stall at the output fills the empty
// stages before in_ready drops. Reset empties the chain and loads the register
// defaults.

module analog_rotary_decode_and_scale_unit
    import ardsu_pkg::*;
#(
    parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [RAW_W-1:0]          raw_count,
    input  logic [MV_W-1:0]           sample_millivolts,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [RAW_W-1:0]          raw_out,
    output logic [MV_W-1:0]           millivolts_out,
    output logic [POS_W-1:0]          position_index,
    output logic                      position_valid,
    output logic signed [SCALE_W-1:0] scaled_value
);

    logic [3:0]         control_reg;
    logic [7:0]         count_reg;
    logic [TOL_W-1:0]   tolerance_reg;
    logic [DATA_W-1:0]  centre_lo_reg;
    logic [DATA_W-1:0]  centre_hi_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [GAIN_W-1:0]  offset_reg;
    logic               wr_en;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [CNT_W-1:0]   pos_count;
    logic [MV_W-1:0]    centre [8];
    logic signed [PROD_W-1:0] prod_full;
    ardsu_item_t        in_item;
    ardsu_item_t        item_chain  [MAX_POSITIONS+1];
    logic               valid_chain [MAX_POSITIONS+1];
    logic               ready_chain [MAX_POSITIONS+1];

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg   <= CONTROL_RESET;
            count_reg     <= COUNT_RESET;
            tolerance_reg <= TOLERANCE_RESET;
            centre_lo_reg <= '0;
            centre_hi_reg <= '0;
            gain_reg      <= GAIN_RESET;
            offset_reg    <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_CONTROL:   control_reg   <= pwdata[3:0];
                REG_COUNT:     count_reg     <= pwdata[7:0];
                REG_TOLERANCE: tolerance_reg <= pwdata[TOL_W-1:0];
                REG_CENTRE_LO: centre_lo_reg <= pwdata;
                REG_CENTRE_HI: centre_hi_reg <= pwdata;
                REG_GAIN:      gain_reg      <= pwdata[GAIN_W-1:0];
                REG_OFFSET:    offset_reg    <= pwdata[GAIN_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CONTROL:   prdata = {{(DATA_W-4){1'b0}}, control_reg};
            REG_COUNT:     prdata = {{(DATA_W-8){1'b0}}, count_reg};
            REG_TOLERANCE: prdata = {{(DATA_W-TOL_W){1'b0}}, tolerance_reg};
            REG_CENTRE_LO: prdata = centre_lo_reg;
            REG_CENTRE_HI: prdata = centre_hi_reg;
            REG_GAIN:      prdata = {{(DATA_W-GAIN_W){1'b0}}, gain_reg};
            REG_OFFSET:    prdata = {{(DATA_W-GAIN_W){1'b0}}, offset_reg};
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        if (count_reg < COUNT_MIN)
        begin
            pos_count = CNT_W'(COUNT_MIN);
        end
        else if (count_reg > 8'(MAX_POSITIONS))
        begin
            pos_count = CNT_W'(MAX_POSITIONS);
        end
        else
        begin
            pos_count = count_reg[CNT_W-1:0];
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_centre
        assign centre[g]     = centre_lo_reg[g*MV_W +: MV_W];
        assign centre[g + 4] = centre_hi_reg[g*MV_W +: MV_W];
    end

    assign prod_full = $signed(gain_reg) * $signed({1'b0, sample_millivolts});

    always_comb
    begin
        in_item       = '0;
        in_item.raw   = raw_count;
        in_item.mv    = sample_millivolts;
        in_item.found = 1'b0;
        in_item.pos   = '0;
        in_item.prod  = prod_full;
    end

    assign item_chain[0]  = in_item;
    assign valid_chain[0] = in_valid;
    assign in_ready       = ready_chain[0];

    for (genvar k = 0; k < MAX_POSITIONS; k++)
    begin : g_cell
        ardsu_cell #(
            .IDX (k)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .centre      (centre[k]),
            .centre_prev (centre[(k == 0) ? k : k - 1]),
            .centre_next (centre[(k == MAX_POSITIONS - 1) ? k : k + 1]),
            .tolerance   (tolerance_reg),
            .is_first    (k == 0),
            .is_last     (CNT_W'(k + 1) == pos_count),
            .active      (CNT_W'(k) < pos_count),
            .up_valid    (valid_chain[k]),
            .up_ready    (ready_chain[k]),
            .up_item     (item_chain[k]),
            .dn_valid    (valid_chain[k + 1]),
            .dn_ready    (ready_chain[k + 1]),
            .dn_item     (item_chain[k + 1])
        );
    end

    ardsu_out_stage u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .control        (control_reg),
        .pos_count      (pos_count),
        .offset         ($signed(offset_reg)),
        .up_valid       (valid_chain[MAX_POSITIONS]),
        .up_ready       (ready_chain[MAX_POSITIONS]),
        .up_item        (item_chain[MAX_POSITIONS]),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .raw_out        (raw_out),
        .millivolts_out (millivolts_out),
        .position_index (position_index),
        .position_valid (position_valid),
        .scaled_value   (scaled_value)
    );

endmodule

// ===== tb/rotary_decode_checker.sv =====
`timescale 1ns / 1ps
// Checker for the analog rotary decode and scale unit: follows register writes,
// predicts each sample's result and compares it with what the unit delivers.
// Depends on ardsu_pkg for widths, register indexes and control bit positions.

module rotary_decode_checker
    import ardsu_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic                      pready,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [RAW_W-1:0]          raw_count,
    input  logic [MV_W-1:0]           sample_millivolts,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [RAW_W-1:0]          raw_out,
    input  logic [MV_W-1:0]           millivolts_out,
    input  logic [POS_W-1:0]          position_index,
    input  logic                      position_valid,
    input  logic signed [SCALE_W-1:0] scaled_value,
    output int                        errors,
    output int                        pending
);

    typedef struct packed {
        logic [RAW_W-1:0]          raw;
        logic [MV_W-1:0]           mv;
        logic [POS_W-1:0]          index;
        logic                      index_valid;
        logic signed [SCALE_W-1:0] scaled;
    } decoded_sample_t;

    localparam longint SCALED_TOP    = (longint'(1) <<< (SCALE_W - 1)) - 1;
    localparam longint SCALED_BOTTOM = -(longint'(1) <<< (SCALE_W - 1));

    logic [3:0]               control_r;
    logic [7:0]               count_r;
    logic [TOL_W-1:0]         tolerance_r;
    logic [63:0]              centres_lo_r;
    logic [63:0]              centres_hi_r;
    logic signed [GAIN_W-1:0] gain_r;
    logic signed [GAIN_W-1:0] offset_r;
    decoded_sample_t          expected_q[$];
    decoded_sample_t          oldest;

    initial begin
        errors = 0;
        pending = 0;
    end

    function automatic longint centre_mv(int k);
        logic [63:0] grp;
        grp = (k < 4) ? centres_lo_r : centres_hi_r;
        return longint'(grp[(k % 4) * 16 +: 16]);
    endfunction

    function automatic longint window_side(longint gap, longint tol);
        longint h;
        h = gap / 2;
        return (h < tol) ? h : tol;
    endfunction

    function automatic decoded_sample_t decode_sample(logic [RAW_W-1:0] raw,
                                                      logic [MV_W-1:0] mv);
        decoded_sample_t d;
        longint n, tol, mvl, c, lo, hi, sum;
        int k;
        d = '0;
        if (!control_r[CTL_BLOCK_EN])
            return d;
        d.raw = raw;
        d.mv = mv;
        mvl = longint'(mv);
        if (control_r[CTL_ROTARY_EN]) begin
            n = longint'(count_r);
            if (n < longint'(COUNT_MIN))
                n = longint'(COUNT_MIN);
            if (n > MAX_POSITIONS_DEF)
                n = MAX_POSITIONS_DEF;
            tol = longint'(tolerance_r);
            for (k = 0; k < n; k++) begin
                c = centre_mv(k);
                lo = window_side((k == 0) ? 2 * tol : c - centre_mv(k - 1), tol);
                hi = window_side((k == n - 1) ? 2 * tol : centre_mv(k + 1) - c, tol);
                if (mvl >= c - lo && mvl <= c + hi) begin
                    d.index_valid = 1'b1;
                    d.index = control_r[CTL_INVERT] ? POS_W'(n - 1 - k) : POS_W'(k);
                    break;
                end
            end
        end
        if (control_r[CTL_SCALE_EN]) begin
            sum = longint'(gain_r) * mvl + longint'(offset_r);
            if (sum > SCALED_TOP)
                sum = SCALED_TOP;
            if (sum < SCALED_BOTTOM)
                sum = SCALED_BOTTOM;
            d.scaled = sum[SCALE_W-1:0];
        end
        return d;
    endfunction

    function automatic void check_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            control_r    = CONTROL_RESET;
            count_r      = COUNT_RESET;
            tolerance_r  = TOLERANCE_RESET;
            centres_lo_r = '0;
            centres_hi_r = '0;
            gain_r       = GAIN_RESET;
            offset_r     = '0;
            expected_q.delete();
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:3])
                    REG_CONTROL:   control_r    = pwdata[3:0];
                    REG_COUNT:     count_r      = pwdata[7:0];
                    REG_TOLERANCE: tolerance_r  = pwdata[TOL_W-1:0];
                    REG_CENTRE_LO: centres_lo_r = pwdata;
                    REG_CENTRE_HI: centres_hi_r = pwdata;
                    REG_GAIN:      gain_r       = pwdata[GAIN_W-1:0];
                    REG_OFFSET:    offset_r     = pwdata[GAIN_W-1:0];
                    default:       ;
                endcase
            end
            if (in_valid && in_ready)
                expected_q.push_back(decode_sample(raw_count, sample_millivolts));
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with no sample outstanding");
                    errors++;
                end
                else begin
                    oldest = expected_q.pop_front();
                    check_field("raw_out", oldest.raw, raw_out);
                    check_field("millivolts_out", oldest.mv, millivolts_out);
                    check_field("position_index", oldest.index, position_index);
                    check_field("position_valid", oldest.index_valid, position_valid);
                    check_field("scaled_value", oldest.scaled, scaled_value);
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

// ===== tb/tb_analog_rotary_decode_and_scale_unit.sv =====
`timescale 1ns / 1ps
// Top of the testbench for the analog rotary decode and scale unit: clock, reset,
// register writes, sample stimulus and output back-pressure, plus the verdict.
// Depends on ardsu_pkg, the unit itself and rotary_decode_checker.

module tb_analog_rotary_decode_and_scale_unit;
    import ardsu_pkg::*;

    localparam int HOLD_OFF_CYCLES = 80;
    localparam int RANDOM_PHASES   = 14;
    localparam int PHASE_SAMPLES   = 50;

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ADDR_W-1:0]         paddr;
    logic [DATA_W-1:0]         pwdata;
    logic                      pready;
    logic                      in_valid;
    logic                      in_ready;
    logic [RAW_W-1:0]          raw_count;
    logic [MV_W-1:0]           sample_millivolts;
    logic                      out_valid;
    logic                      out_ready;
    logic [RAW_W-1:0]          raw_out;
    logic [MV_W-1:0]           millivolts_out;
    logic [POS_W-1:0]          position_index;
    logic                      position_valid;
    logic signed [SCALE_W-1:0] scaled_value;
    int                        check_errors;
    int                        check_pending;

    bit                        hold_off_req;
    int                        burst_left;
    logic [7:0]                shadow_count;
    logic [TOL_W-1:0]          shadow_tol;
    logic [63:0]               shadow_lo;
    logic [63:0]               shadow_hi;

    analog_rotary_decode_and_scale_unit i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .raw_count         (raw_count),
        .sample_millivolts (sample_millivolts),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .raw_out           (raw_out),
        .millivolts_out    (millivolts_out),
        .position_index    (position_index),
        .position_valid    (position_valid),
        .scaled_value      (scaled_value)
    );

    rotary_decode_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .pready            (pready),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .raw_count         (raw_count),
        .sample_millivolts (sample_millivolts),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .raw_out           (raw_out),
        .millivolts_out    (millivolts_out),
        .position_index    (position_index),
        .position_valid    (position_valid),
        .scaled_value      (scaled_value),
        .errors            (check_errors),
        .pending           (check_pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [3:0] control_word(bit blk, bit rot, bit inv, bit scl);
        logic [3:0] w;
        w = '0;
        w[CTL_BLOCK_EN]  = blk;
        w[CTL_ROTARY_EN] = rot;
        w[CTL_INVERT]    = inv;
        w[CTL_SCALE_EN]  = scl;
        return w;
    endfunction

    function automatic logic [31:0] pick_q16(logic [31:0] typical);
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom;
            3:       return 32'(int'($urandom_range(0, 262144)) - 131072);
            default: return typical;
        endcase
    endfunction

    // Mostly samples close to a calibrated centre, so that windows and their edges are hit.
    function automatic logic [MV_W-1:0] pick_millivolts();
        int n, k, span, v;
        if ($urandom_range(0, 9) < 3)
            return $urandom_range(0, 65535);
        n = (shadow_count < COUNT_MIN) ? 2 :
            (shadow_count > MAX_POSITIONS_DEF) ? MAX_POSITIONS_DEF : int'(shadow_count);
        k = $urandom_range(0, n - 1);
        span = ((shadow_tol > 1000) ? 1000 : int'(shadow_tol)) + 2;
        v = (k < 4) ? int'(shadow_lo[k * 16 +: 16]) : int'(shadow_hi[(k - 4) * 16 +: 16]);
        v = v + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[MV_W-1:0];
    endfunction

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (check_pending != 0)
            @(posedge clk);
    endtask

    task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        wait_until_drained();
        case (idx)
            REG_COUNT:     shadow_count = value[7:0];
            REG_TOLERANCE: shadow_tol   = value[TOL_W-1:0];
            REG_CENTRE_LO: shadow_lo    = value;
            REG_CENTRE_HI: shadow_hi    = value;
            default:       ;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_sample(logic [RAW_W-1:0] raw, logic [MV_W-1:0] mv);
        int gap;
        in_valid          <= 1'b1;
        raw_count         <= raw;
        sample_millivolts <= mv;
        do
            @(posedge clk);
        while (!in_ready);
        gap = (burst_left > 0) ? 0 : pick_gap();
        if (burst_left > 0)
            burst_left--;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic random_setup();
        logic [3:0]  ctl;
        logic [7:0]  cnt;
        logic [15:0] tol;
        logic [15:0] c[8];
        logic [15:0] t;
        int          base, step, a, b, k, mode;
        ctl = $urandom_range(0, 15);
        if ($urandom_range(0, 9) != 0)
            ctl[CTL_BLOCK_EN] = 1'b1;
        case ($urandom_range(0, 5))
            0:       cnt = 8'd0;
            1:       cnt = 8'd255;
            2:       cnt = 8'd1;
            default: cnt = $urandom_range(2, MAX_POSITIONS_DEF);
        endcase
        case ($urandom_range(0, 5))
            0:       tol = 16'd0;
            1:       tol = 16'hFFFF;
            2:       tol = $urandom_range(0, 65535);
            default: tol = $urandom_range(1, 600);
        endcase
        mode = $urandom_range(0, 4);
        base = $urandom_range(0, 2000);
        step = $urandom_range(0, 3000);
        for (k = 0; k < 8; k++)
            c[k] = (mode == 0) ? 16'($urandom_range(0, 65535)) : 16'(base + k * step);
        if (mode == 1) begin
            a = $urandom_range(0, 7);
            b = $urandom_range(0, 7);
            t = c[a];
            c[a] = c[b];
            c[b] = t;
        end
        write_register(REG_CONTROL, 64'(ctl));
        write_register(REG_COUNT, 64'(cnt));
        write_register(REG_TOLERANCE, 64'(tol));
        write_register(REG_CENTRE_LO, {c[3], c[2], c[1], c[0]});
        write_register(REG_CENTRE_HI, {c[7], c[6], c[5], c[4]});
        write_register(REG_GAIN, 64'(pick_q16(GAIN_RESET)));
        write_register(REG_OFFSET, 64'(pick_q16(32'd0)));
    endtask

    initial begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat (($urandom_range(0, 9) < 2) ? $urandom_range(20, 60) : $urandom_range(1, 8))
                @(posedge clk);
            begin
                int stall;
                stall = pick_gap();
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    initial begin
        int phase, n;
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        in_valid          <= 1'b0;
        raw_count         <= '0;
        sample_millivolts <= '0;
        hold_off_req = 1'b0;
        burst_left   = 0;
        shadow_count = COUNT_RESET;
        shadow_tol   = TOLERANCE_RESET;
        shadow_lo    = '0;
        shadow_hi    = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The unit comes out of reset disabled, so every result field must be zero.
        send_sample(12'hFFF, 16'hFFFF);
        send_sample(12'h000, 16'h0000);

        write_register(REG_CONTROL, 64'(control_word(1, 1, 1, 1)));
        write_register(REG_COUNT, 64'd8);
        write_register(REG_TOLERANCE, 64'd100);
        write_register(REG_CENTRE_LO, {16'd4000, 16'd3000, 16'd2000, 16'd1000});
        write_register(REG_CENTRE_HI, {16'd8000, 16'd7000, 16'd6000, 16'd5000});
        send_sample(12'h5A5, 16'd1000);
        send_sample(12'hA5A, 16'd900);
        send_sample(12'h001, 16'd899);
        send_sample(12'h002, 16'd1100);
        send_sample(12'h003, 16'd1101);
        send_sample(12'h004, 16'd8100);
        send_sample(12'h005, 16'd8101);

        // With the widest tolerance the half gaps to neighbours set the inner edges.
        write_register(REG_TOLERANCE, 64'hFFFF);
        send_sample(12'h006, 16'd0);
        send_sample(12'h007, 16'd1500);
        send_sample(12'h008, 16'd1501);
        send_sample(12'h009, 16'hFFFF);

        write_register(REG_CONTROL, 64'(control_word(1, 1, 0, 0)));
        send_sample(12'h00A, 16'd4500);
        write_register(REG_CONTROL, 64'(control_word(1, 0, 0, 1)));
        send_sample(12'h00B, 16'd3000);

        write_register(REG_CONTROL, 64'(control_word(1, 1, 1, 1)));
        write_register(REG_COUNT, 64'd0);
        send_sample(12'h00C, 16'd60000);
        write_register(REG_COUNT, 64'd255);
        send_sample(12'h00D, 16'd7600);

        // Centres out of order, including an odd negative gap.
        write_register(REG_TOLERANCE, 64'd300);
        write_register(REG_CENTRE_LO, {16'd1000, 16'd3001, 16'd2000, 16'd500});
        send_sample(12'h00E, 16'd1000);
        send_sample(12'h00F, 16'd2000);
        send_sample(12'h010, 16'd1999);
        send_sample(12'h011, 16'd3001);

        write_register(REG_GAIN, 64'h8000_0000);
        write_register(REG_OFFSET, 64'h8000_0000);
        send_sample(12'h012, 16'hFFFF);
        send_sample(12'h013, 16'h0000);
        write_register(REG_GAIN, 64'h7FFF_FFFF);
        write_register(REG_OFFSET, 64'h7FFF_FFFF);
        send_sample(12'h014, 16'hFFFF);

        write_register(REG_TOLERANCE, 64'd0);
        send_sample(12'h015, 16'd5000);
        send_sample(12'h016, 16'd5001);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_setup();
            if ($urandom_range(0, 9) < 3)
                burst_left = 20;
            for (n = 0; n < PHASE_SAMPLES; n++) begin
                if (phase == 4 && n == 5) begin
                    hold_off_req = 1'b1;
                    burst_left = 60;
                    in_valid <= 1'b0;
                    wait (!hold_off_req);
                end
                send_sample($urandom_range(0, 4095), pick_millivolts());
            end
        end

        wait_until_drained();
        repeat (MAX_POSITIONS_DEF + 4) @(posedge clk);
        if (check_errors == 0 && check_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ardsu_pkg.sv
rtl/ardsu_cell.sv
rtl/ardsu_out_stage.sv
rtl/analog_rotary_decode_and_scale_unit.sv
tb/rotary_decode_checker.sv
tb/tb_analog_rotary_decode_and_scale_unit.sv
